[rtl/lfct_pkg.sv]
package lfct_pkg;

  // Table geometry.
  localparam int TABLE_DEPTH = 2048;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int DATA_W      = 11;
  localparam int COORD_W     = 11;
  localparam int ERR_W       = 15;

  // Register map.
  localparam logic CFG_REG_MAX_INDEX = 1'b0;

  // Item kinds carried in the input tuser.
  localparam logic ACT_DRAW = 1'b0;
  localparam logic ACT_READ = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_RESULT
  } state_t;

  // Line endpoints after range check, all within 0..max_index.
  typedef struct packed {
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] y0;
    logic [COORD_W-1:0] x1;
    logic [COORD_W-1:0] y1;
  } line_t;

  // Write request into the table memory.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } wr_req_t;

endpackage

[rtl/line_fill_curve_table.sv]
// Curve table filled by straight line draws, read back one entry at a time.
// Input channel in_*: tuser[0] selects draw (0) or read (1); tdata carries
// start_x, start_y, end_x, end_y (13-bit signed each) and read_index.
// Output channel out_*: one result per request, tdata holds read_value and
// tuser[0] the rejected flag. The cfg_* APB port holds max_index at 0x0.
// A draw with any coordinate outside 0..max_index writes nothing and
// returns rejected. An accepted draw walks the line and writes one table
// entry per cycle along its major axis, then passes its result to the
// output register. A read or a rejected draw goes straight to the result
// state; the read value comes from the registered memory read. One request
// is in work at a time; the next can be taken in the cycle after the result
// moves to the output register, even while the receiver stalls it. A
// stalled result holds until out_tready. Reset clears the control state and
// sets max_index to 2047; the table contents are undefined until written.
module line_fill_curve_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata: start_x[12:0], start_y[25:13], end_x[38:26], end_y[51:39],
  //        read_index[62:52], zero[63]
  input  logic [63:0] in_tdata,
  // tuser: action[0]
  input  logic [0:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata: read_value[10:0], zero[15:11]
  output logic [15:0] out_tdata,
  // tuser: rejected[0]
  output logic [0:0]  out_tuser,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int CW = lfct_pkg::COORD_W;
  localparam int DW = lfct_pkg::DATA_W;

  lfct_pkg::state_t  state_r, state_nxt;
  logic [CW-1:0]     max_index_r;
  logic              res_read_r, res_read_nxt;
  logic              res_rej_r, res_rej_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DW-1:0]     out_value_r, out_value_nxt;
  logic              out_rej_r, out_rej_nxt;

  logic signed [12:0] start_x, start_y, end_x, end_y;
  logic [10:0]        read_index;
  logic               action;
  logic               accept;
  logic               coords_ok;
  logic               read_ok;
  logic               walk_start;
  logic               walk_done;
  logic               out_free;
  lfct_pkg::line_t    line;
  lfct_pkg::wr_req_t  wr;
  logic [DW-1:0]      rd_data;

  // Field unpacking.
  assign start_x    = in_tdata[12:0];
  assign start_y    = in_tdata[25:13];
  assign end_x      = in_tdata[38:26];
  assign end_y      = in_tdata[51:39];
  assign read_index = in_tdata[62:52];
  assign action     = in_tuser[0];

  // Configuration port.
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == lfct_pkg::CFG_REG_MAX_INDEX) ?
                      {{(32-CW){1'b0}}, max_index_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_index_r <= '1;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == lfct_pkg::CFG_REG_MAX_INDEX) begin
      max_index_r <= cfg_pwdata[CW-1:0];
    end
  end

  // Range check of the four endpoints against max_index.
  assign coords_ok = !start_x[12] && (start_x[11:0] <= {1'b0, max_index_r}) &&
                     !start_y[12] && (start_y[11:0] <= {1'b0, max_index_r}) &&
                     !end_x[12]   && (end_x[11:0]   <= {1'b0, max_index_r}) &&
                     !end_y[12]   && (end_y[11:0]   <= {1'b0, max_index_r});
  assign read_ok   = int'(read_index) < lfct_pkg::TABLE_DEPTH;

  assign in_tready  = (state_r == lfct_pkg::ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign walk_start = accept && (action == lfct_pkg::ACT_DRAW) && coords_ok;
  assign out_free   = !out_valid_r || out_tready;

  always_comb begin
    line.x0 = start_x[CW-1:0];
    line.y0 = start_y[CW-1:0];
    line.x1 = end_x[CW-1:0];
    line.y1 = end_y[CW-1:0];
  end

  // Request sequencing and the output register.
  always_comb begin
    state_nxt     = state_r;
    res_read_nxt  = res_read_r;
    res_rej_nxt   = res_rej_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_rej_nxt   = out_rej_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      lfct_pkg::ST_IDLE: begin
        if (accept) begin
          if (action == lfct_pkg::ACT_READ) begin
            res_read_nxt = read_ok;
            res_rej_nxt  = 1'b0;
            state_nxt    = lfct_pkg::ST_RESULT;
          end else if (coords_ok) begin
            res_read_nxt = 1'b0;
            res_rej_nxt  = 1'b0;
            state_nxt    = lfct_pkg::ST_WALK;
          end else begin
            res_read_nxt = 1'b0;
            res_rej_nxt  = 1'b1;
            state_nxt    = lfct_pkg::ST_RESULT;
          end
        end
      end
      lfct_pkg::ST_WALK: begin
        if (walk_done) begin
          state_nxt = lfct_pkg::ST_RESULT;
        end
      end
      lfct_pkg::ST_RESULT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = res_read_r ? rd_data : '0;
          out_rej_nxt   = res_rej_r;
          state_nxt     = lfct_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lfct_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lfct_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_read_r  <= res_read_nxt;
    res_rej_r   <= res_rej_nxt;
    out_value_r <= out_value_nxt;
    out_rej_r   <= out_rej_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(16-DW){1'b0}}, out_value_r};
  assign out_tuser  = out_rej_r;

  // Line stepper writing into the table.
  lfct_walker u_walker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (walk_start),
    .line  (line),
    .wr    (wr),
    .done  (walk_done)
  );

  // Table storage; a read is issued when the read request is taken.
  lfct_table_mem u_mem (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (accept && (action == lfct_pkg::ACT_READ)),
    .rd_addr (lfct_pkg::ADDR_W'(read_index)),
    .rd_data (rd_data)
  );

endmodule

[rtl/lfct_table_mem.sv]
module lfct_table_mem (
  input  logic                          clk,
  input  lfct_pkg::wr_req_t             wr,
  input  logic                          rd_en,
  input  logic [lfct_pkg::ADDR_W-1:0]   rd_addr,
  output logic [lfct_pkg::DATA_W-1:0]   rd_data
);

  logic [lfct_pkg::DATA_W-1:0] mem [lfct_pkg::TABLE_DEPTH];
  logic [lfct_pkg::DATA_W-1:0] rd_data_r;

  // Single write port.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/lfct_walker.sv]
module lfct_walker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  lfct_pkg::line_t   line,
  output lfct_pkg::wr_req_t wr,
  output logic              done
);

  localparam int CW = lfct_pkg::COORD_W;
  localparam int EW = lfct_pkg::ERR_W;

  logic                 busy_r, busy_nxt;
  logic [CW-1:0]        x_r, x_nxt;
  logic [CW-1:0]        y_r, y_nxt;
  logic [CW-1:0]        x1_r, x1_nxt;
  logic [CW-1:0]        y1_r, y1_nxt;
  logic [CW:0]          ax_r, ax_nxt;
  logic [CW:0]          ay_r, ay_nxt;
  logic                 sx_neg_r, sx_neg_nxt;
  logic                 sy_neg_r, sy_neg_nxt;
  logic                 xmaj_r, xmaj_nxt;
  logic signed [EW-1:0] err_r, err_nxt;

  logic signed [CW:0]   dx, dy;
  logic [CW:0]          ndx, ndy;
  logic [CW-1:0]        abs_dx, abs_dy;
  logic [CW:0]          ax0, ay0;
  logic signed [EW-1:0] ax_s, ay_s;
  logic                 at_end;
  logic                 err_ge;

  // Setup of a new line: deltas and doubled magnitudes; the initial error is set in the step logic.
  always_comb begin
    dx     = $signed({1'b0, line.x1}) - $signed({1'b0, line.x0});
    dy     = $signed({1'b0, line.y1}) - $signed({1'b0, line.y0});
    ndx    = -dx;
    ndy    = -dy;
    abs_dx = dx[CW] ? ndx[CW-1:0] : dx[CW-1:0];
    abs_dy = dy[CW] ? ndy[CW-1:0] : dy[CW-1:0];
    ax0    = {abs_dx, 1'b0};
    ay0    = {abs_dy, 1'b0};
  end

  assign ax_s   = $signed({{(EW-CW-1){1'b0}}, ax_r});
  assign ay_s   = $signed({{(EW-CW-1){1'b0}}, ay_r});
  assign at_end = xmaj_r ? (x_r == x1_r) : (y_r == y1_r);
  assign err_ge = !err_r[EW-1];

  // Loads a new line on start, then one Bresenham step per cycle while busy.
  always_comb begin
    busy_nxt   = busy_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    x1_nxt     = x1_r;
    y1_nxt     = y1_r;
    ax_nxt     = ax_r;
    ay_nxt     = ay_r;
    sx_neg_nxt = sx_neg_r;
    sy_neg_nxt = sy_neg_r;
    xmaj_nxt   = xmaj_r;
    err_nxt    = err_r;
    if (start) begin
      busy_nxt   = 1'b1;
      x_nxt      = line.x0;
      y_nxt      = line.y0;
      x1_nxt     = line.x1;
      y1_nxt     = line.y1;
      ax_nxt     = ax0;
      ay_nxt     = ay0;
      sx_neg_nxt = !(dx > 0);
      sy_neg_nxt = !(dy > 0);
      xmaj_nxt   = ax0 > ay0;
      if (ax0 > ay0) begin
        err_nxt = $signed({{(EW-CW-1){1'b0}}, ay0}) - $signed({{(EW-CW){1'b0}}, abs_dx});
      end else begin
        err_nxt = $signed({{(EW-CW-1){1'b0}}, ax0}) - $signed({{(EW-CW){1'b0}}, abs_dy});
      end
    end else if (busy_r) begin
      if (at_end) begin
        busy_nxt = 1'b0;
      end else if (xmaj_r) begin
        x_nxt = sx_neg_r ? x_r - 1'b1 : x_r + 1'b1;
        if (err_ge) begin
          y_nxt   = sy_neg_r ? y_r - 1'b1 : y_r + 1'b1;
          err_nxt = err_r + ay_s - ax_s;
        end else begin
          err_nxt = err_r + ay_s;
        end
      end else begin
        y_nxt = sy_neg_r ? y_r - 1'b1 : y_r + 1'b1;
        if (err_ge) begin
          x_nxt   = sx_neg_r ? x_r - 1'b1 : x_r + 1'b1;
          err_nxt = err_r + ax_s - ay_s;
        end else begin
          err_nxt = err_r + ax_s;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r      <= x_nxt;
    y_r      <= y_nxt;
    x1_r     <= x1_nxt;
    y1_r     <= y1_nxt;
    ax_r     <= ax_nxt;
    ay_r     <= ay_nxt;
    sx_neg_r <= sx_neg_nxt;
    sy_neg_r <= sy_neg_nxt;
    xmaj_r   <= xmaj_nxt;
    err_r    <= err_nxt;
  end

  // Every visited point is stored, y at address x; an 11-bit x always lies within the table.
  always_comb begin
    wr.en   = busy_r && (int'(x_r) < lfct_pkg::TABLE_DEPTH);
    wr.addr = lfct_pkg::ADDR_W'(x_r);
    wr.data = lfct_pkg::DATA_W'(y_r);
  end

  assign done = busy_r && at_end;

endmodule
